FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KECT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kect assertion failed");

// antecedent implies consequent in the next cycle
`define KECT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kect assertion failed");

`endif

FILE: rtl/kect_pkg.sv
// types and constants of the keyed event counter table
package kect_pkg;

  localparam int SLOT_COUNT_DEF   = 512;
  localparam int COUNTER_BITS_DEF = 32;
  localparam int NCNT             = 10;

  localparam int C_SUBMIT     = 0;
  localparam int C_RESUME     = 1;
  localparam int C_VERIFIED   = 2;
  localparam int C_REJECTED   = 3;
  localparam int C_CHECKPOINT = 4;
  localparam int C_RENEW      = 5;
  localparam int C_RECLAIM    = 6;
  localparam int C_RELEASE    = 7;
  localparam int C_RETRY      = 8;
  localparam int C_DEAD       = 9;

  typedef enum logic [2:0] {
    MODE_PROV     = 3'd0,
    MODE_PRIN     = 3'd1,
    MODE_CLASS    = 3'd2,
    MODE_SCHED    = 3'd3,
    MODE_READ     = 3'd4,
    MODE_RST_KIND = 3'd5,
    MODE_RST_ALL  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PROV  = 2'd0,
    KIND_PRIN  = 2'd1,
    KIND_CLASS = 2'd2,
    KIND_SCHED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_RENEW   = 3'd0,
    EV_RECLAIM = 3'd1,
    EV_RELEASE = 3'd2,
    EV_RETRY   = 3'd3,
    EV_DEAD    = 3'd4
  } sched_ev_e;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_IGNORED = 3'd1,
    ST_FULL    = 3'd2,
    ST_HIT     = 3'd3,
    ST_MISS    = 3'd4,
    ST_RESET   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CRD,
    S_CUSE,
    S_CLAIM,
    S_KCLR
  } state_e;

  typedef struct packed {
    logic [31:0] db;
    logic [1:0]  kind;
    logic [31:0] ent;
    logic [31:0] cls;
  } key_t;

  typedef struct packed {
    logic            key_we;
    logic            cnt_we;
    logic            row_clr;
    logic [NCNT-1:0] bump;
    logic            res_load;
    logic            res_hit;
    status_e         res_status;
  } ctl_t;

endpackage

FILE: rtl/kect_ram.sv
// generic single write port ram with registered read
module kect_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/kect_row_upd.sv
// saturating counter row update unit
module kect_row_upd import kect_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic [NCNT*COUNTER_BITS-1:0] row_i,
  input  logic                         clr_i,
  input  logic [NCNT-1:0]              bump_i,
  output logic [NCNT*COUNTER_BITS-1:0] row_o
);

  logic [COUNTER_BITS-1:0] cur [NCNT];

  always_comb begin
    row_o = '0;
    for (int k = 0; k < NCNT; k++) begin
      cur[k] = clr_i ? '0 : row_i[k*COUNTER_BITS +: COUNTER_BITS];
      if (bump_i[k] && (cur[k] != '1)) begin
        row_o[k*COUNTER_BITS +: COUNTER_BITS] = cur[k] + COUNTER_BITS'(1);
      end else begin
        row_o[k*COUNTER_BITS +: COUNTER_BITS] = cur[k];
      end
    end
  end

endmodule

FILE: rtl/kect_seq.sv
// sequencer: slot scan with the shared key comparator, claim, update and sweep
module kect_seq import kect_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int IdxW  = $clog2(SLOT_COUNT),
  localparam int FillW = $clog2(SLOT_COUNT + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            track_en_i,
  input  logic [2:0]      mode_i,
  input  logic [31:0]     db_id_i,
  input  logic [31:0]     entity_id_i,
  input  logic [31:0]     class_tag_i,
  input  logic [1:0]      kind_sel_i,
  input  logic            resume_i,
  input  logic            flag_i,
  input  logic [2:0]      event_code_i,
  input  key_t            key_rdata_i,
  output logic [IdxW-1:0] key_raddr_o,
  output logic [IdxW-1:0] key_waddr_o,
  output key_t            key_wdata_o,
  output logic [IdxW-1:0] cnt_addr_o,
  output logic            busy_o,
  output ctl_t            ctl_o
);

  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  idx_q, idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q;
  logic [IdxW-1:0]   slot_q, slot_d;
  logic [2:0]        mode_q;
  key_t              key_q;
  key_t              in_key;
  logic              resume_q;
  logic              flag_q;
  logic [2:0]        code_q;
  logic [1:0]        in_kind;
  logic              in_ignore;
  logic              scan_issue;
  logic              scan_end;
  logic              key_hit;
  logic              kind_hit;
  logic              is_read;
  logic              full;
  logic              fill_clr;
  logic              fill_inc;
  logic [NCNT-1:0]   mask;

  // key normalization of the incoming transaction
  always_comb begin
    in_kind       = mode_i[2] ? kind_sel_i : mode_i[1:0];
    in_key.db     = db_id_i;
    in_key.kind   = in_kind;
    if ((in_kind == KIND_PROV) || (in_kind == KIND_PRIN)) begin
      in_key.ent = entity_id_i;
      in_key.cls = '0;
      in_ignore  = !track_en_i || (entity_id_i == '0);
    end else begin
      in_key.ent = '0;
      in_key.cls = class_tag_i;
      in_ignore  = !track_en_i || (class_tag_i == '0);
    end
  end

  assign scan_issue = idx_q < fill_q;
  assign scan_end   = !scan_issue && !chk_vld_q;
  assign key_hit    = chk_vld_q && (key_rdata_i == key_q);
  assign kind_hit   = chk_vld_q && (key_rdata_i.kind == key_q.kind);
  assign is_read    = mode_q == MODE_READ;
  assign full       = fill_q == FillW'(SLOT_COUNT);

  // counters touched by an update
  always_comb begin
    mask = '0;
    if (mode_q != MODE_SCHED) begin
      if (resume_q) begin
        mask[C_RESUME] = 1'b1;
      end else begin
        mask[C_SUBMIT] = 1'b1;
      end
      if (mode_q == MODE_PROV) begin
        if (flag_q) begin
          mask[C_VERIFIED] = 1'b1;
        end else begin
          mask[C_REJECTED] = 1'b1;
        end
      end else if (flag_q) begin
        mask[C_CHECKPOINT] = 1'b1;
      end
    end else begin
      unique case (code_q)
        EV_RENEW:   mask[C_RENEW]   = 1'b1;
        EV_RECLAIM: mask[C_RECLAIM] = 1'b1;
        EV_RELEASE: mask[C_RELEASE] = 1'b1;
        EV_RETRY:   mask[C_RETRY]   = 1'b1;
        EV_DEAD:    mask[C_DEAD]    = 1'b1;
        default:    mask            = '0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_PROV, MODE_PRIN, MODE_CLASS, MODE_SCHED: begin
              if (!in_ignore) state_d = S_SCAN;
            end
            MODE_READ:     state_d = S_SCAN;
            MODE_RST_KIND: state_d = S_KCLR;
            default:       state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          state_d = S_CRD;
        end else if (scan_end) begin
          state_d = (is_read || full) ? S_IDLE : S_CLAIM;
        end
      end
      S_CRD:   state_d = S_CUSE;
      S_CUSE:  state_d = S_IDLE;
      S_CLAIM: state_d = S_IDLE;
      S_KCLR: begin
        if (scan_end) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o            = '0;
    ctl_o.res_status = ST_IGNORED;
    fill_clr         = 1'b0;
    fill_inc         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_PROV, MODE_PRIN, MODE_CLASS, MODE_SCHED: begin
              ctl_o.res_load = in_ignore;
            end
            MODE_READ, MODE_RST_KIND: ctl_o.res_load = 1'b0;
            MODE_RST_ALL: begin
              ctl_o.res_load   = 1'b1;
              ctl_o.res_status = ST_RESET;
              fill_clr         = 1'b1;
            end
            default: ctl_o.res_load = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (!key_hit && scan_end) begin
          ctl_o.res_load   = is_read || full;
          ctl_o.res_status = is_read ? ST_MISS : ST_FULL;
        end
      end
      S_CRD: ctl_o.res_load = 1'b0;
      S_CUSE: begin
        ctl_o.res_load = 1'b1;
        if (is_read) begin
          ctl_o.res_hit    = 1'b1;
          ctl_o.res_status = ST_HIT;
        end else begin
          ctl_o.cnt_we     = 1'b1;
          ctl_o.bump       = mask;
          ctl_o.res_status = ST_UPDATED;
        end
      end
      S_CLAIM: begin
        ctl_o.key_we     = 1'b1;
        ctl_o.cnt_we     = 1'b1;
        ctl_o.row_clr    = 1'b1;
        ctl_o.bump       = mask;
        ctl_o.res_load   = 1'b1;
        ctl_o.res_status = ST_UPDATED;
        fill_inc         = 1'b1;
      end
      S_KCLR: begin
        ctl_o.cnt_we  = kind_hit;
        ctl_o.row_clr = kind_hit;
        if (scan_end) begin
          ctl_o.res_load   = 1'b1;
          ctl_o.res_status = ST_RESET;
        end
      end
      default: ctl_o.res_load = 1'b0;
    endcase
  end

  // scan pointer, fill count and slot
  always_comb begin
    idx_d     = idx_q;
    chk_vld_d = chk_vld_q;
    slot_d    = slot_q;
    fill_d    = fill_q;
    if (state_q == S_IDLE) begin
      idx_d     = '0;
      chk_vld_d = 1'b0;
    end else if ((state_q == S_SCAN) || (state_q == S_KCLR)) begin
      chk_vld_d = scan_issue && !((state_q == S_SCAN) && key_hit);
      idx_d     = idx_q + FillW'(scan_issue);
    end
    if (state_q == S_SCAN) begin
      if (key_hit) begin
        slot_d = chk_idx_q;
      end else if (scan_end) begin
        slot_d = fill_q[IdxW-1:0];
      end
    end
    if (fill_clr) begin
      fill_d = '0;
    end else if (fill_inc) begin
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= idx_q[IdxW-1:0];
    slot_q    <= slot_d;
    if ((state_q == S_IDLE) && start_i) begin
      mode_q   <= mode_i;
      key_q    <= in_key;
      resume_q <= resume_i;
      flag_q   <= flag_i;
      code_q   <= event_code_i;
    end
  end

  assign key_raddr_o = idx_q[IdxW-1:0];
  assign key_waddr_o = slot_q;
  assign key_wdata_o = key_q;
  assign cnt_addr_o  = (state_q == S_KCLR) ? chk_idx_q : slot_q;
  assign busy_o      = state_q != S_IDLE;

endmodule

FILE: rtl/keyed_event_counter_table.sv
// top level of the keyed event counter table
//
// Command channel: a transaction is taken when start is high and busy is low;
// its fields are sampled at that edge. busy stays high while it is worked on.
// Each transaction gives one result, shown for one cycle with done_o high; the
// receiver cannot stall it, and a new start may be given in that same cycle.
// Config channel: cfg_track_enable_i is written when cfg_valid_i and
// cfg_ready_o are high; cfg_ready_o is always high. Write it only while idle.
// Ignored transactions and reset-all give the result in the cycle after start.
// Reads and updates scan the F claimed slots (F <= SLOT_COUNT) one slot per
// cycle through a single key comparator on the key memory read port. The
// scan stops at a hit, whose counter row is then read and used; a read miss
// or a full table ends it with no claim, and an update miss claims the next
// slot. Reset-kind sweeps the F claimed slots. The result comes in the cycle
// after the last busy cycle.
// Slots are claimed in order, so a fill count marks the used ones: reset
// clears it at once and no clearing pass is needed. Reset also sets
// track_enable to one.
module keyed_event_counter_table import kect_pkg::*; #(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [31:0] db_id_i,
  input  logic [31:0] entity_id_i,
  input  logic [31:0] class_tag_i,
  input  logic [1:0]  kind_sel_i,
  input  logic        resume_i,
  input  logic        flag_i,
  input  logic [2:0]  event_code_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_track_enable_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] submit_count_o,
  output logic [31:0] resume_count_o,
  output logic [31:0] verified_count_o,
  output logic [31:0] rejected_count_o,
  output logic [31:0] checkpoint_total_o,
  output logic [31:0] renew_total_o,
  output logic [31:0] reclaim_total_o,
  output logic [31:0] release_total_o,
  output logic [31:0] retry_total_o,
  output logic [31:0] dead_letter_total_o,
  output logic [32:0] run_total_o
);

  localparam int IdxW = $clog2(SLOT_COUNT);
  localparam int RowW = NCNT * COUNTER_BITS;

  ctl_t            ctl;
  key_t            key_rdata;
  key_t            key_wdata;
  logic [IdxW-1:0] key_raddr;
  logic [IdxW-1:0] key_waddr;
  logic [IdxW-1:0] cnt_addr;
  logic [RowW-1:0] cnt_rdata;
  logic [RowW-1:0] cnt_wdata;
  logic            track_en_q;
  logic            done_q;
  logic [2:0]      status_q;
  logic [31:0]     fld [NCNT];
  logic [31:0]     res_q [NCNT];
  logic [32:0]     run_q;

  kect_seq #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .track_en_i  (track_en_q),
    .mode_i,
    .db_id_i,
    .entity_id_i,
    .class_tag_i,
    .kind_sel_i,
    .resume_i,
    .flag_i,
    .event_code_i,
    .key_rdata_i (key_rdata),
    .key_raddr_o (key_raddr),
    .key_waddr_o (key_waddr),
    .key_wdata_o (key_wdata),
    .cnt_addr_o  (cnt_addr),
    .busy_o      (busy),
    .ctl_o       (ctl)
  );

  kect_ram #(
    .WIDTH($bits(key_t)),
    .DEPTH(SLOT_COUNT)
  ) u_key_ram (
    .clk_i,
    .we_i    (ctl.key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  kect_ram #(
    .WIDTH(RowW),
    .DEPTH(SLOT_COUNT)
  ) u_cnt_ram (
    .clk_i,
    .we_i    (ctl.cnt_we),
    .waddr_i (cnt_addr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_addr),
    .rdata_o (cnt_rdata)
  );

  kect_row_upd #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_row_upd (
    .row_i  (cnt_rdata),
    .clr_i  (ctl.row_clr),
    .bump_i (ctl.bump),
    .row_o  (cnt_wdata)
  );

  always_comb begin
    for (int k = 0; k < NCNT; k++) begin
      fld[k] = 32'(cnt_rdata[k*COUNTER_BITS +: COUNTER_BITS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_en_q <= 1'b1;
      done_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        track_en_q <= cfg_track_enable_i;
      end
      done_q <= ctl.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.res_load) begin
      status_q <= ctl.res_status;
      for (int k = 0; k < NCNT; k++) begin
        res_q[k] <= ctl.res_hit ? fld[k] : '0;
      end
      run_q <= ctl.res_hit ? ({1'b0, fld[C_SUBMIT]} + {1'b0, fld[C_RESUME]}) : '0;
    end
  end

  assign cfg_ready_o         = 1'b1;
  assign done_o              = done_q;
  assign status_o            = status_q;
  assign submit_count_o      = res_q[C_SUBMIT];
  assign resume_count_o      = res_q[C_RESUME];
  assign verified_count_o    = res_q[C_VERIFIED];
  assign rejected_count_o    = res_q[C_REJECTED];
  assign checkpoint_total_o  = res_q[C_CHECKPOINT];
  assign renew_total_o       = res_q[C_RENEW];
  assign reclaim_total_o     = res_q[C_RECLAIM];
  assign release_total_o     = res_q[C_RELEASE];
  assign retry_total_o       = res_q[C_RETRY];
  assign dead_letter_total_o = res_q[C_DEAD];
  assign run_total_o         = run_q;

endmodule

FILE: rtl/kect_checker.sv
// port level checker of the keyed event counter table and its bind
`include "assert_macros.svh"

module kect_checker import kect_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] submit_count_o,
  input logic [31:0] resume_count_o,
  input logic [32:0] run_total_o
);

  logic [32:0] run_want;

  assign run_want = {1'b0, submit_count_o} + {1'b0, resume_count_o};

  `KECT_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `KECT_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  `KECT_ASSERT_SAME(a_run_zero, clk_i, rst_ni, done_o && (status_o != ST_HIT), run_total_o == '0)
  `KECT_ASSERT_SAME(a_run_sum, clk_i, rst_ni, done_o && (status_o == ST_HIT), run_total_o == run_want)

endmodule

bind keyed_event_counter_table kect_checker u_kect_checker (.*);

FILE: tb/tb_keyed_event_counter_table.sv
// self-checking testbench for the keyed event counter table: directed rows, tracking off, table fill, random mix
module tb_keyed_event_counter_table;
  import kect_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int CW = COUNTER_BITS_DEF;
  localparam int POOL = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [2:0] EV_OTHER = 3'd5;
  localparam logic [2:0] EV_SPARE = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] db;
    logic [31:0] ent;
    logic [31:0] cls;
    logic [1:0]  ksel;
    logic        resume;
    logic        flag;
    logic [2:0]  code;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [9:0][31:0] cnt;
    logic [32:0]      run;
  } result_t;

  typedef struct packed {
    logic [31:0] db;
    logic [1:0]  kind;
    logic [31:0] ent;
    logic [31:0] cls;
  } slot_key_t;

  typedef struct packed {
    cmd_t    c;
    logic    typed;
    status_e want;
  } row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode_i = '0;
  logic [31:0] db_id_i = '0;
  logic [31:0] entity_id_i = '0;
  logic [31:0] class_tag_i = '0;
  logic [1:0]  kind_sel_i = '0;
  logic        resume_i = 1'b0;
  logic        flag_i = 1'b0;
  logic [2:0]  event_code_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_track_enable_i = 1'b0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] submit_count_o;
  logic [31:0] resume_count_o;
  logic [31:0] verified_count_o;
  logic [31:0] rejected_count_o;
  logic [31:0] checkpoint_total_o;
  logic [31:0] renew_total_o;
  logic [31:0] reclaim_total_o;
  logic [31:0] release_total_o;
  logic [31:0] retry_total_o;
  logic [31:0] dead_letter_total_o;
  logic [32:0] run_total_o;

  keyed_event_counter_table u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .db_id_i            (db_id_i),
    .entity_id_i        (entity_id_i),
    .class_tag_i        (class_tag_i),
    .kind_sel_i         (kind_sel_i),
    .resume_i           (resume_i),
    .flag_i             (flag_i),
    .event_code_i       (event_code_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_track_enable_i (cfg_track_enable_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .submit_count_o     (submit_count_o),
    .resume_count_o     (resume_count_o),
    .verified_count_o   (verified_count_o),
    .rejected_count_o   (rejected_count_o),
    .checkpoint_total_o (checkpoint_total_o),
    .renew_total_o      (renew_total_o),
    .reclaim_total_o    (reclaim_total_o),
    .release_total_o    (release_total_o),
    .retry_total_o      (retry_total_o),
    .dead_letter_total_o(dead_letter_total_o),
    .run_total_o        (run_total_o)
  );

  // shadow copy of the slot table
  bit                        track_en = 1'b1;
  bit                        used [SLOTS];
  logic [31:0]               key_db [SLOTS];
  logic [1:0]                key_kind [SLOTS];
  logic [31:0]               key_ent [SLOTS];
  logic [31:0]               key_cls [SLOTS];
  logic [NCNT-1:0][CW-1:0]   ctr [SLOTS];

  result_t   awaited_results [$];
  row_t      directed_rows [$];
  slot_key_t pool [POOL];
  slot_key_t filled [SLOTS];
  int        mismatches = 0;
  int        stall_cycles = 0;
  bit        calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what, input logic [32:0] got,
                               input logic [32:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  function automatic int lookup(logic [31:0] db, logic [1:0] kind, logic [31:0] ent,
                                logic [31:0] cls);
    for (int i = 0; i < SLOTS; i++)
      if (used[i] && key_db[i] == db && key_kind[i] == kind && key_ent[i] == ent &&
          key_cls[i] == cls)
        return i;
    return -1;
  endfunction

  function automatic void bump(int s, int which);
    if (ctr[s][which] != '1) ctr[s][which] = ctr[s][which] + 1'b1;
  endfunction

  task automatic table_access(input cmd_t c, output result_t r);
    logic [1:0]  kd;
    logic [31:0] e;
    logic [31:0] k;
    int          s;
    r = '0;
    e = c.ent;
    k = c.cls;
    if (c.mode <= MODE_SCHED) begin
      kd = c.mode[1:0];
      if (!track_en || (kd <= KIND_PRIN && e == '0) || (kd >= KIND_CLASS && k == '0)) begin
        r.status = ST_IGNORED;
      end else begin
        if (kd <= KIND_PRIN) k = '0;
        else e = '0;
        s = lookup(c.db, kd, e, k);
        if (s < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (!used[i]) begin
              s = i;
              break;
            end
          if (s >= 0) begin
            used[s] = 1'b1;
            key_db[s] = c.db;
            key_kind[s] = kd;
            key_ent[s] = e;
            key_cls[s] = k;
            ctr[s] = '0;
          end
        end
        if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          if (kd <= KIND_CLASS) begin
            bump(s, c.resume ? C_RESUME : C_SUBMIT);
            if (kd == KIND_PROV) bump(s, c.flag ? C_VERIFIED : C_REJECTED);
            else if (c.flag) bump(s, C_CHECKPOINT);
          end else if (c.code <= EV_DEAD) begin
            bump(s, C_RENEW + int'(c.code));
          end
          r.status = ST_UPDATED;
        end
      end
    end else if (c.mode == MODE_READ) begin
      if (c.ksel <= KIND_PRIN) k = '0;
      else e = '0;
      s = lookup(c.db, c.ksel, e, k);
      if (s < 0) begin
        r.status = ST_MISS;
      end else begin
        r.status = ST_HIT;
        for (int j = 0; j < NCNT; j++) r.cnt[j] = ctr[s][j][31:0];
        r.run = {1'b0, r.cnt[C_SUBMIT]} + {1'b0, r.cnt[C_RESUME]};
      end
    end else if (c.mode == MODE_RST_KIND) begin
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && key_kind[i] == c.ksel) ctr[i] = '0;
      r.status = ST_RESET;
    end else if (c.mode == MODE_RST_ALL) begin
      for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
      r.status = ST_RESET;
    end else begin
      r.status = ST_IGNORED;
    end
  endtask

  task automatic issue(input cmd_t c, input logic typed, input status_e want);
    result_t r;
    start <= 1'b1;
    mode_i <= c.mode;
    db_id_i <= c.db;
    entity_id_i <= c.ent;
    class_tag_i <= c.cls;
    kind_sel_i <= c.ksel;
    resume_i <= c.resume;
    flag_i <= c.flag;
    event_code_i <= c.code;
    do @(posedge clk_i); while (busy);
    table_access(c, r);
    if (typed) begin
      r = '0;
      r.status = want;
    end
    awaited_results.push_back(r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_track_enable(input logic v);
    cfg_valid_i <= 1'b1;
    cfg_track_enable_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    track_en = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic row_t mk_row(logic [2:0] m, logic [31:0] db, logic [31:0] ent,
                                  logic [31:0] cls, logic [1:0] ks, int rs, int fl,
                                  logic [2:0] cd, int typed, status_e want);
    row_t rw;
    rw.c = '{mode: m, db: db, ent: ent, cls: cls, ksel: ks, resume: 1'(rs), flag: 1'(fl),
             code: cd};
    rw.typed = 1'(typed);
    rw.want = want;
    return rw;
  endfunction

  function automatic logic [31:0] nonzero();
    logic [31:0] v;
    do v = $urandom; while (v == '0);
    return v;
  endfunction

  function automatic slot_key_t fresh_key();
    slot_key_t k;
    k.db = $urandom;
    k.kind = 2'($urandom_range(0, 3));
    k.ent = nonzero();
    k.cls = nonzero();
    return k;
  endfunction

  // fields outside the key carry random noise
  function automatic cmd_t key_cmd(slot_key_t k, logic [2:0] m);
    cmd_t c;
    c.mode = m;
    c.db = k.db;
    c.ksel = (m == MODE_READ) ? k.kind : 2'($urandom_range(0, 3));
    c.resume = 1'($urandom_range(0, 1));
    c.flag = 1'($urandom_range(0, 1));
    c.code = 3'($urandom_range(0, 7));
    if (k.kind <= KIND_PRIN) begin
      c.ent = k.ent;
      c.cls = $urandom;
    end else begin
      c.ent = $urandom;
      c.cls = k.cls;
    end
    return c;
  endfunction

  function automatic cmd_t mixed_cmd();
    slot_key_t k;
    cmd_t      c;
    int        sel;
    sel = $urandom_range(0, 99);
    k = pool[$urandom_range(0, POOL - 1)];
    if (sel < 55) begin
      c = key_cmd(k, {1'b0, k.kind});
    end else if (sel < 80) begin
      c = key_cmd(k, MODE_READ);
    end else if (sel < 85) begin
      c = key_cmd(fresh_key(), MODE_READ);
    end else if (sel < 89) begin
      c = key_cmd(k, {1'b0, k.kind});
      if (k.kind <= KIND_PRIN) c.ent = '0;
      else c.cls = '0;
    end else if (sel < 92) begin
      c = key_cmd(fresh_key(), MODE_UNUSED);
    end else if (sel < 94) begin
      k = fresh_key();
      c = key_cmd(k, {1'b0, k.kind});
    end else if (sel < 98) begin
      c = key_cmd(k, MODE_RST_KIND);
    end else begin
      c = key_cmd(k, MODE_RST_ALL);
    end
    return c;
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t seen;
    if (rst_ni && done_o) begin
      seen.status = status_e'(status_o);
      seen.cnt = {dead_letter_total_o, retry_total_o, release_total_o, reclaim_total_o,
                  renew_total_o, checkpoint_total_o, rejected_count_o, verified_count_o,
                  resume_count_o, submit_count_o};
      seen.run = run_total_o;
      if (awaited_results.size() == 0) begin
        note_mismatch("result with none awaited", 33'(status_o), '0);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status !== want.status)
          note_mismatch("status", 33'(seen.status), 33'(want.status));
        for (int j = 0; j < NCNT; j++)
          if (seen.cnt[j] !== want.cnt[j])
            note_mismatch($sformatf("counter %0d", j), 33'(seen.cnt[j]), 33'(want.cnt[j]));
        if (seen.run !== want.run) note_mismatch("run total", seen.run, want.run);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    slot_key_t k;
    int        sel;
    for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;

    // after reset, extremes, normalization, every update kind and every named event code
    directed_rows.push_back(mk_row(MODE_READ, '0, 32'd1, '0, KIND_PROV, 0, 0, EV_RENEW,
                                   1, ST_MISS));
    directed_rows.push_back(mk_row(MODE_PROV, '0, 32'd1, '0, KIND_PROV, 0, 1, EV_RENEW,
                                   1, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_PROV, '1, '1, '1, KIND_SCHED, 1, 0, EV_SPARE,
                                   1, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_PROV, 32'd5, '0, 32'd3, KIND_PROV, 0, 1, EV_RENEW,
                                   1, ST_IGNORED));
    directed_rows.push_back(mk_row(MODE_READ, '1, '1, 32'h1234, KIND_PROV, 0, 0, EV_RENEW,
                                   0, ST_HIT));
    directed_rows.push_back(mk_row(MODE_PRIN, 32'd5, 32'd7, '0, KIND_PRIN, 0, 1, EV_RENEW,
                                   0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_PRIN, 32'd5, 32'd7, 32'd9, KIND_PRIN, 1, 0, EV_DEAD,
                                   0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_READ, 32'd5, 32'd7, 32'd44, KIND_PRIN, 0, 0, EV_RENEW,
                                   0, ST_HIT));
    directed_rows.push_back(mk_row(MODE_CLASS, 32'd5, 32'd8, '0, KIND_CLASS, 0, 1, EV_RENEW,
                                   1, ST_IGNORED));
    directed_rows.push_back(mk_row(MODE_CLASS, 32'd5, 32'd99, '1, KIND_CLASS, 0, 1, EV_RENEW,
                                   0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_READ, 32'd5, 32'd3, '1, KIND_CLASS, 0, 0, EV_RENEW,
                                   0, ST_HIT));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, 32'd1, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_RENEW, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, 32'd2, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_RECLAIM, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, '0, 32'hABC, KIND_SCHED, 1, 1,
                                   EV_RELEASE, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, '1, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_RETRY, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, 32'd4, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_DEAD, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, 32'd4, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_OTHER, 0, ST_UPDATED));
    directed_rows.push_back(mk_row(MODE_READ, 32'd5, 32'd6, 32'hABC, KIND_SCHED, 0, 0,
                                   EV_RENEW, 0, ST_HIT));
    directed_rows.push_back(mk_row(MODE_UNUSED, 32'd5, 32'd7, 32'hABC, KIND_PRIN, 0, 0,
                                   EV_RENEW, 1, ST_IGNORED));
    directed_rows.push_back(mk_row(MODE_SCHED, 32'd5, 32'd7, '0, KIND_SCHED, 0, 0,
                                   EV_RENEW, 1, ST_IGNORED));
    directed_rows.push_back(mk_row(MODE_RST_KIND, '0, '0, '0, KIND_PRIN, 0, 0, EV_RENEW,
                                   1, ST_RESET));
    directed_rows.push_back(mk_row(MODE_READ, 32'd5, 32'd7, '0, KIND_PRIN, 0, 0, EV_RENEW,
                                   0, ST_HIT));
    directed_rows.push_back(mk_row(MODE_RST_ALL, '0, '0, '0, KIND_PROV, 0, 0, EV_RENEW,
                                   1, ST_RESET));
    directed_rows.push_back(mk_row(MODE_READ, 32'd5, '0, 32'hABC, KIND_SCHED, 0, 0, EV_RENEW,
                                   1, ST_MISS));

    for (int i = 0; i < POOL; i++) begin
      pool[i] = fresh_key();
      sel = $urandom_range(0, 3);
      if (sel == 0) pool[i].db = '0;
      else if (sel == 1) pool[i].db = '1;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

    // tracking off: updates ignored, reads and resets still act
    wait_drained();
    write_track_enable(1'b0);
    repeat (30) issue(mixed_cmd(), 1'b0, ST_UPDATED);
    wait_drained();
    write_track_enable(1'b1);

    // fill every slot, then hit a full table
    issue(key_cmd(pool[0], MODE_RST_ALL), 1'b0, ST_RESET);
    for (int i = 0; i < SLOTS; i++) begin
      filled[i] = fresh_key();
      issue(key_cmd(filled[i], {1'b0, filled[i].kind}), 1'b0, ST_UPDATED);
    end
    repeat (30) begin
      sel = $urandom_range(0, 29);
      k = filled[$urandom_range(0, SLOTS - 1)];
      if (sel < 12) begin
        k = fresh_key();
        issue(key_cmd(k, {1'b0, k.kind}), 1'b0, ST_UPDATED);
      end else if (sel < 20) begin
        issue(key_cmd(k, {1'b0, k.kind}), 1'b0, ST_UPDATED);
      end else if (sel < 29) begin
        issue(key_cmd(k, MODE_READ), 1'b0, ST_UPDATED);
      end else begin
        issue(key_cmd(k, MODE_RST_KIND), 1'b0, ST_UPDATED);
      end
    end
    issue(key_cmd(pool[0], MODE_RST_ALL), 1'b0, ST_RESET);

    for (int n = 0; n < 560; n++) begin
      if (n == 460) calm = 1'b1;
      if ($urandom_range(0, 49) == 0) wait_drained();
      issue(mixed_cmd(), 1'b0, ST_UPDATED);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
